>>> rtl/gma_pkg.sv
package gma_pkg;

  // Input command codes carried in tuser.
  localparam logic CMD_LABEL = 1'b0;
  localparam logic CMD_EDGE  = 1'b1;

  // Result status codes carried in tuser.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // Fixed field widths.
  localparam int ROW_W   = 10;
  localparam int LABEL_W = 8;
  localparam int ACC_W   = 48;
  localparam int COUNT_W = 21;
  localparam int CFG_W   = 9;
  localparam int FRAC_SH = 24;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Control for the cluster accumulator memories.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clear;
  } acc_ctl_t;

  // Saturating add of two 48-bit signed values.
  function automatic logic signed [ACC_W-1:0] sat_add48(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    s = $signed({a[ACC_W-1], a}) + $signed({b[ACC_W-1], b});
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add48 = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_add48 = s[ACC_W-1:0];
    end
  endfunction

  // Magnitude of a 48-bit signed value as an unsigned 48-bit value.
  function automatic logic [ACC_W-1:0] mag48(input logic signed [ACC_W-1:0] x);
    mag48 = x[ACC_W-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

>>> rtl/gma_label_store.sv
module gma_label_store #(
  parameter int MAX_NODES = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rd_en,
  input  logic [$clog2(MAX_NODES)-1:0]        rd_a_addr,
  input  logic [$clog2(MAX_NODES)-1:0]        rd_b_addr,
  input  logic                                wr_en,
  input  logic [$clog2(MAX_NODES)-1:0]        wr_addr,
  input  logic [gma_pkg::LABEL_W-1:0]         wr_data,
  output logic [gma_pkg::LABEL_W-1:0]         rd_a,
  output logic [gma_pkg::LABEL_W-1:0]         rd_b,
  output logic                                busy
);

  localparam int NB = $clog2(MAX_NODES);

  logic [gma_pkg::LABEL_W-1:0] mem [MAX_NODES];
  logic [NB-1:0]               clr_addr;

  // Clearing pass after reset: one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == NB'(MAX_NODES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Single write port, shared with the clearing pass.
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two registered read ports for the row and column labels.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= mem[rd_a_addr];
      rd_b <= mem[rd_b_addr];
    end
  end

endmodule

>>> rtl/gma_cluster_acc.sv
module gma_cluster_acc #(
  parameter int MAX_CLUSTERS = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  gma_pkg::acc_ctl_t                      ctl,
  input  logic [$clog2(MAX_CLUSTERS)-1:0]        addr,
  input  logic signed [gma_pkg::ACC_W-1:0]       wr_int,
  input  logic signed [gma_pkg::ACC_W-1:0]       wr_deg,
  output logic signed [gma_pkg::ACC_W-1:0]       rd_int,
  output logic signed [gma_pkg::ACC_W-1:0]       rd_deg
);

  logic signed [gma_pkg::ACC_W-1:0] mem_int [MAX_CLUSTERS];
  logic signed [gma_pkg::ACC_W-1:0] mem_deg [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0]          valid;
  logic signed [gma_pkg::ACC_W-1:0] q_int;
  logic signed [gma_pkg::ACC_W-1:0] q_deg;
  logic                             q_valid;

  // Entry valid bits; an invalid entry reads as zero.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= '0;
    end else if (ctl.wr) begin
      valid[addr] <= 1'b1;
    end
  end

  // Both sums of an entry are always written together.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem_int[addr] <= wr_int;
      mem_deg[addr] <= wr_deg;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      q_int   <= mem_int[addr];
      q_deg   <= mem_deg[addr];
      q_valid <= valid[addr];
    end
  end

  assign rd_int = q_valid ? q_int : '0;
  assign rd_deg = q_valid ? q_deg : '0;

endmodule

>>> rtl/gma_divider.sv
module gma_divider #(
  parameter int DVD_W = 72,
  parameter int DVS_W = 21,
  parameter int QUO_W = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DVS_W:0]   trial;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
    end else if (run) begin
      dvd      <= {dvd[DVD_W-2:0], 1'b0};
      rem      <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      quotient <= {quotient[QUO_W-2:0], fits};
      cnt      <= cnt + 1'b1;
      if (cnt == CNT_W'(DVD_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/graph_modularity_accumulator.sv
// Channel  Direction  Handshake                  Payload
// s_axis   in         s_axis_tvalid/tready       tdata row,col,label,weight; tuser cmd; tlast
// m_axis   out        m_axis_tvalid/tready       tdata score; tuser status
// cfg      in         cfg_valid/cfg_ready        cfg_data cluster_count
//
// A label load is written as it is accepted; a nonzero goes through the label memory read,
// then the read and write back of the cluster memories.
// The result pass takes each cluster in turn through the 72-step serial dividers
// (two, run side by side), after a setup state and before the output state.
// After reset the label memory is cleared one entry per cycle, and s_axis_tready
// is low until it is done; cfg writes are always taken.
// A finished result waits in the output register while new items are accepted.
module graph_modularity_accumulator #(
  parameter int MAX_NODES    = 1024,
  parameter int MAX_CLUSTERS = 256,
  parameter int WEIGHT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // row_node[9:0], col_node[19:10], label[27:20], weight, zero fill
  input  logic [((28 + WEIGHT_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // cmd
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // score[47:0]
  output logic [47:0]           m_axis_tdata,
  // status[1:0]
  output logic [1:0]            m_axis_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [gma_pkg::CFG_W-1:0] cfg_data
);

  localparam int NB    = $clog2(MAX_NODES);
  localparam int CB    = $clog2(MAX_CLUSTERS);
  localparam int AW    = gma_pkg::ACC_W;
  localparam int SUM_W = AW + 3 + CB;
  localparam int DVD_W = AW + gma_pkg::FRAC_SH;
  localparam int LAB_LO = 2 * gma_pkg::ROW_W;
  localparam int W_LO   = LAB_LO + gma_pkg::LABEL_W;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_LAB       = 4'd1;
  localparam logic [3:0] S_ACC       = 4'd2;
  localparam logic [3:0] S_FIN_START = 4'd3;
  localparam logic [3:0] S_FIN_ISSUE = 4'd4;
  localparam logic [3:0] S_FIN_RD    = 4'd5;
  localparam logic [3:0] S_FIN_DIV   = 4'd6;
  localparam logic [3:0] S_FIN_MUL   = 4'd7;
  localparam logic [3:0] S_FIN_SUM   = 4'd8;
  localparam logic [3:0] S_FIN_OUT   = 4'd9;

  localparam logic [AW:0] CAP = {1'b1, {AW{1'b0}}};
  localparam logic [AW:0] SQ_LIMIT = (AW + 1)'(64'd1 << 40);

  logic [3:0] state;
  logic [gma_pkg::CFG_W-1:0] cluster_count;
  logic [gma_pkg::COUNT_W-1:0] count;

  // Input field views.
  logic [gma_pkg::ROW_W-1:0]   in_row;
  logic [gma_pkg::ROW_W-1:0]   in_col;
  logic [gma_pkg::LABEL_W-1:0] in_label;
  logic [WEIGHT_WIDTH-1:0]     in_weight;
  logic                        in_accept;
  logic                        in_row_ok;
  logic                        in_col_ok;

  // Nonzero context.
  logic signed [AW-1:0] w_q;
  logic                 last_q;
  logic                 row_ok_q;
  logic                 col_ok_q;
  logic [CB-1:0]        lr_q;
  logic                 match_q;

  // Label memory interface.
  logic [gma_pkg::LABEL_W-1:0] lab_a;
  logic [gma_pkg::LABEL_W-1:0] lab_b;
  logic                        lab_busy;
  logic                        lab_ok;

  // Cluster memory interface.
  gma_pkg::acc_ctl_t    acc_ctl;
  logic [CB-1:0]        acc_addr;
  logic signed [AW-1:0] acc_wr_int;
  logic signed [AW-1:0] acc_wr_deg;
  logic signed [AW-1:0] acc_rd_int;
  logic signed [AW-1:0] acc_rd_deg;

  // Result pass.
  logic [CB:0]            cidx;
  logic [CB:0]            nc;
  logic signed [SUM_W-1:0] qsum;
  logic                   sat_q;
  logic                   empty_q;
  logic                   sign_w;
  logic                   sign_d;
  logic                   satw_q;
  logic                   satd_q;
  logic [AW:0]            vw;
  logic [AW:0]            vd;
  logic signed [AW+1:0]   wa_q;
  logic                   sqsat_q;
  logic [63:0]            p0;
  logic [39:0]            p1;
  logic [15:0]            p2;
  logic                   div_start;
  logic [AW-1:0]          mw;
  logic [AW-1:0]          md;
  logic [AW-1:0]          n_shift;
  logic [AW-1:0]          qw;
  logic [AW-1:0]          qd;
  logic                   done_w;
  logic                   done_d;
  logic [AW:0]            sq;
  logic signed [AW+2:0]   term;
  logic [SUM_W-AW:0]      q_hi;
  logic                   q_ovf;
  logic                   out_free;

  assign in_row    = s_axis_tdata[gma_pkg::ROW_W-1:0];
  assign in_col    = s_axis_tdata[LAB_LO-1:gma_pkg::ROW_W];
  assign in_label  = s_axis_tdata[W_LO-1:LAB_LO];
  assign in_weight = s_axis_tdata[W_LO+WEIGHT_WIDTH-1:W_LO];
  assign in_row_ok = {22'd0, in_row} < 32'(MAX_NODES);
  assign in_col_ok = {22'd0, in_col} < 32'(MAX_NODES);

  assign s_axis_tready = (state == S_IDLE) && !lab_busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign lab_ok = {24'd0, lab_a} < 32'(MAX_CLUSTERS);
  assign nc = (32'(cluster_count) > 32'(MAX_CLUSTERS)) ? (CB + 1)'(MAX_CLUSTERS)
                                                       : (CB + 1)'(cluster_count);

  gma_label_store #(.MAX_NODES(MAX_NODES)) u_labels (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_accept && (s_axis_tuser == gma_pkg::CMD_EDGE)),
    .rd_a_addr (NB'(in_row)),
    .rd_b_addr (NB'(in_col)),
    .wr_en     (in_accept && (s_axis_tuser == gma_pkg::CMD_LABEL) && in_row_ok),
    .wr_addr   (NB'(in_row)),
    .wr_data   (in_label),
    .rd_a      (lab_a),
    .rd_b      (lab_b),
    .busy      (lab_busy)
  );

  // Cluster memory control and write-back values.
  always_comb begin
    acc_ctl    = '0;
    acc_addr   = lr_q;
    acc_wr_deg = gma_pkg::sat_add48(acc_rd_deg, w_q);
    acc_wr_int = match_q ? gma_pkg::sat_add48(acc_rd_int, w_q) : acc_rd_int;
    unique case (state)
      S_LAB: begin
        acc_ctl.rd = row_ok_q && lab_ok;
        acc_addr   = CB'(lab_a);
      end
      S_ACC: begin
        acc_ctl.wr = 1'b1;
      end
      S_FIN_ISSUE: begin
        acc_ctl.rd = 1'b1;
        acc_addr   = cidx[CB-1:0];
      end
      S_FIN_OUT: begin
        acc_ctl.clear = out_free;
      end
      default: begin
      end
    endcase
  end

  gma_cluster_acc #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_acc (
    .clk    (clk),
    .rst    (rst),
    .ctl    (acc_ctl),
    .addr   (acc_addr),
    .wr_int (acc_wr_int),
    .wr_deg (acc_wr_deg),
    .rd_int (acc_rd_int),
    .rd_deg (acc_rd_deg)
  );

  // Divider operands for the averages S * 2^24 / n.
  assign mw        = gma_pkg::mag48(acc_rd_int);
  assign md        = gma_pkg::mag48(acc_rd_deg);
  assign n_shift   = AW'({count, {gma_pkg::FRAC_SH{1'b0}}});
  assign div_start = (state == S_FIN_RD);

  gma_divider #(.DVD_W(DVD_W), .DVS_W(gma_pkg::COUNT_W), .QUO_W(AW)) u_div_w (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({mw, {gma_pkg::FRAC_SH{1'b0}}}),
    .divisor  (count),
    .quotient (qw),
    .done     (done_w)
  );

  gma_divider #(.DVD_W(DVD_W), .DVS_W(gma_pkg::COUNT_W), .QUO_W(AW)) u_div_d (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({md, {gma_pkg::FRAC_SH{1'b0}}}),
    .divisor  (count),
    .quotient (qd),
    .done     (done_d)
  );

  // Square from registered partial products, and the cluster term.
  always_comb begin
    sq   = sqsat_q ? CAP
                   : (AW + 1)'({p2, 32'd0}) + (AW + 1)'({p1, 1'b0}) + (AW + 1)'(p0[63:32]);
    term = $signed({wa_q[AW+1], wa_q}) - $signed({2'b00, sq});
    q_hi = qsum[SUM_W-1:AW-1];
    q_ovf = !((&q_hi) || !(|q_hi));
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= gma_pkg::CFG_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      cluster_count <= cfg_data;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // A new result in the output stage takes the place of one leaving it.
      if (m_axis_tvalid && m_axis_tready && (state != S_FIN_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            w_q      <= AW'($signed(in_weight));
            last_q   <= s_axis_tlast;
            row_ok_q <= in_row_ok;
            col_ok_q <= in_col_ok;
            if (s_axis_tuser == gma_pkg::CMD_EDGE) begin
              if (count != gma_pkg::COUNT_MAX) begin
                count <= count + 1'b1;
              end
              state <= S_LAB;
            end else if (s_axis_tlast) begin
              state <= S_FIN_START;
            end
          end
        end
        S_LAB: begin
          lr_q    <= CB'(lab_a);
          match_q <= col_ok_q && (lab_b == lab_a);
          if (row_ok_q && lab_ok) begin
            state <= S_ACC;
          end else begin
            state <= last_q ? S_FIN_START : S_IDLE;
          end
        end
        S_ACC: begin
          state <= last_q ? S_FIN_START : S_IDLE;
        end
        S_FIN_START: begin
          empty_q <= (count == '0);
          qsum    <= '0;
          sat_q   <= 1'b0;
          cidx    <= '0;
          state   <= ((count == '0) || (nc == '0)) ? S_FIN_OUT : S_FIN_ISSUE;
        end
        S_FIN_ISSUE: begin
          state <= S_FIN_RD;
        end
        S_FIN_RD: begin
          sign_w <= acc_rd_int[AW-1];
          sign_d <= acc_rd_deg[AW-1];
          satw_q <= mw >= n_shift;
          satd_q <= md >= n_shift;
          state  <= S_FIN_DIV;
        end
        S_FIN_DIV: begin
          if (done_w && done_d) begin
            vw    <= satw_q ? CAP : {1'b0, qw};
            vd    <= satd_q ? CAP : {1'b0, qd};
            sat_q <= sat_q || satw_q || satd_q;
            state <= S_FIN_MUL;
          end
        end
        S_FIN_MUL: begin
          // The sign of D/n does not matter for the square.
          wa_q    <= (sign_w && !sign_d) || (sign_w && sign_d) ? -$signed({1'b0, vw})
                                                               : $signed({1'b0, vw});
          sqsat_q <= vd >= SQ_LIMIT;
          sat_q   <= sat_q || (vd >= SQ_LIMIT);
          p0      <= {32'd0, vd[31:0]} * {32'd0, vd[31:0]};
          p1      <= {32'd0, vd[39:32]} * {8'd0, vd[31:0]};
          p2      <= {8'd0, vd[39:32]} * {8'd0, vd[39:32]};
          state   <= S_FIN_SUM;
        end
        S_FIN_SUM: begin
          qsum <= qsum + SUM_W'(term);
          if (cidx + 1'b1 == nc) begin
            state <= S_FIN_OUT;
          end else begin
            cidx  <= cidx + 1'b1;
            state <= S_FIN_ISSUE;
          end
        end
        S_FIN_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            count         <= '0;
            state         <= S_IDLE;
            if (empty_q) begin
              m_axis_tdata <= '0;
              m_axis_tuser <= gma_pkg::ST_EMPTY;
            end else begin
              m_axis_tdata <= q_ovf ? (qsum[SUM_W-1] ? gma_pkg::ACC_MIN : gma_pkg::ACC_MAX)
                                    : qsum[AW-1:0];
              m_axis_tuser <= (sat_q || q_ovf) ? gma_pkg::ST_SAT : gma_pkg::ST_OK;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/gma_checker.sv
module gma_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // The label clearing pass holds off input right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input accepted during label clearing pass");

  // Status is one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == gma_pkg::ST_OK) ||
                      (m_axis_tuser == gma_pkg::ST_EMPTY) ||
                      (m_axis_tuser == gma_pkg::ST_SAT))
    else $error("undefined status code");

  // An empty graph reports a zero score.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == gma_pkg::ST_EMPTY)) |-> (m_axis_tdata == '0))
    else $error("empty graph with nonzero score");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

bind graph_modularity_accumulator gma_checker u_gma_checker (.*);

>>> tb/sv/graph_modularity_accumulator_tb.sv
`timescale 1ns / 1ps

module graph_modularity_accumulator_tb;

  localparam int  TDATA_W   = 48;
  localparam int  NODES     = 1024;
  localparam int  CLUSTERS  = 256;
  localparam int  LIMIT     = 200000000;
  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -64'sh0000_8000_0000_0000;
  localparam longint CAP    = 64'sh0001_0000_0000_0000;

  typedef struct {
    logic               cmd;
    logic [9:0]         row;
    logic [9:0]         col;
    logic [7:0]         label;
    logic signed [15:0] weight;
    logic               last;
  } gma_item_t;

  // One row of the directed table; known results are typed in where obvious.
  typedef struct {
    gma_item_t   item;
    bit          typed;
    logic [47:0] score;
    logic [1:0]  status;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gma_pkg::CFG_W-1:0] cfg_data = '0;

  graph_modularity_accumulator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state.
  logic [7:0] pred_labels [NODES];
  longint     pred_internal [CLUSTERS];
  longint     pred_degree [CLUSTERS];
  int         pred_count;
  int         pred_clusters;

  logic [49:0] score_queue [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cycles = 0;
  bit quiet_send = 0;
  bit quiet_recv = 0;

  function automatic longint sat48(longint s);
    if (s > SAT_HI) return SAT_HI;
    if (s < SAT_LO) return SAT_LO;
    return s;
  endfunction

  // Sum times 2^24 over the count, truncated toward zero, capped at 2^48.
  function automatic longint scaled_mean(longint s, longint n, inout bit sat);
    longint a, q, r, v;
    a = (s < 0) ? -s : s;
    q = a / n;
    r = a % n;
    if (q >= (64'sd1 << 24)) begin
      v = CAP;
      sat = 1;
    end else begin
      v = (q << 24) + ((r << 24) / n);
    end
    return (s < 0) ? -v : v;
  endfunction

  function automatic longint square_q32(longint d, inout bit sat);
    longint unsigned m, mh, ml;
    m = (d < 0) ? -d : d;
    mh = m >> 32;
    ml = m & 64'hFFFF_FFFF;
    if (mh >= 256) begin
      sat = 1;
      return CAP;
    end
    return longint'(((mh * mh) << 32) + 2 * mh * ml + ((ml * ml) >> 32));
  endfunction

  task automatic clear_sums();
    for (int c = 0; c < CLUSTERS; c++) begin
      pred_internal[c] = 0;
      pred_degree[c] = 0;
    end
    pred_count = 0;
  endtask

  // Applies one accepted item and forms the result, if any.
  task automatic predict_item(input gma_item_t it, output bit has_res,
                              output logic [47:0] sc, output logic [1:0] st);
    int lr, nc;
    longint q;
    bit sat;
    has_res = 0;
    sc = '0;
    st = gma_pkg::ST_OK;
    if (it.cmd == gma_pkg::CMD_LABEL) begin
      pred_labels[it.row] = it.label;
    end else begin
      if (pred_count < int'(gma_pkg::COUNT_MAX)) pred_count++;
      lr = pred_labels[it.row];
      pred_degree[lr] = sat48(pred_degree[lr] + longint'(it.weight));
      if (pred_labels[it.col] == lr)
        pred_internal[lr] = sat48(pred_internal[lr] + longint'(it.weight));
    end
    if (it.last) begin
      has_res = 1;
      if (pred_count == 0) begin
        st = gma_pkg::ST_EMPTY;
      end else begin
        q = 0;
        sat = 0;
        nc = (pred_clusters > CLUSTERS) ? CLUSTERS : pred_clusters;
        for (int c = 0; c < nc; c++) begin
          q += scaled_mean(pred_internal[c], pred_count, sat)
             - square_q32(scaled_mean(pred_degree[c], pred_count, sat), sat);
        end
        if (q > SAT_HI) begin q = SAT_HI; sat = 1; end
        if (q < SAT_LO) begin q = SAT_LO; sat = 1; end
        sc = q[47:0];
        st = sat ? gma_pkg::ST_SAT : gma_pkg::ST_OK;
      end
      clear_sums();
    end
  endtask

  function automatic int gap_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sends one item; returns at the edge where the transfer happened.
  task automatic send_item(input gma_item_t it, input bit typed,
                           input logic [47:0] t_score, input logic [1:0] t_status);
    int gap;
    bit has_res;
    logic [47:0] sc;
    logic [1:0] st;
    gap = gap_len(quiet_send);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, it.weight, it.label, it.col, it.row};
    s_axis_tuser <= it.cmd;
    s_axis_tlast <= it.last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    predict_item(it, has_res, sc, st);
    if (has_res) score_queue.push_back(typed ? {t_status, t_score} : {st, sc});
  endtask

  task automatic write_clusters(input int value);
    cfg_valid <= 1'b1;
    cfg_data <= value[gma_pkg::CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pred_clusters = value & 9'h1FF;
  endtask

  // Wait for every pending result, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (score_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic gma_item_t mk(logic cmd, int row, int col, int label, int weight,
                                   logic last);
    gma_item_t it;
    it.cmd = cmd;
    it.row = row[9:0];
    it.col = col[9:0];
    it.label = label[7:0];
    it.weight = weight[15:0];
    it.last = last;
    return it;
  endfunction

  // Receiver stalls: mostly short, sometimes long, none in quiet stretches.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet_recv && $urandom_range(0, 7) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (score_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result score=%h status=%0d", $time, m_axis_tdata,
                 m_axis_tuser);
      end else begin
        if (score_queue[0][47:0] !== m_axis_tdata) begin
          errors++;
          $display("%0t: score expected %h actual %h", $time, score_queue[0][47:0],
                   m_axis_tdata);
        end
        if (score_queue[0][49:48] !== m_axis_tuser) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, score_queue[0][49:48],
                   m_axis_tuser);
        end
        void'(score_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("graph_modularity_accumulator: mismatch");
      $finish;
    end
  end

  directed_row_t table_rows [$];
  initial begin
    int phase, cc, nlabels, nedges, pool;
    gma_item_t it;
    for (int i = 0; i < NODES; i++) pred_labels[i] = '0;
    clear_sums();
    pred_clusters = CLUSTERS;

    // Directed rows: empty graphs, extreme nodes, labels and weights.
    table_rows.push_back('{mk(gma_pkg::CMD_LABEL, 0, 0, 0, 0, 1), 1, 48'd0,
                           gma_pkg::ST_EMPTY});
    table_rows.push_back('{mk(gma_pkg::CMD_EDGE, 0, 0, 0, 32767, 1), 0, 48'd0,
                           gma_pkg::ST_OK});
    table_rows.push_back('{mk(gma_pkg::CMD_LABEL, 1023, 1023, 255, -1, 0), 0, 48'd0,
                           gma_pkg::ST_OK});
    table_rows.push_back('{mk(gma_pkg::CMD_LABEL, 1, 0, 1, 0, 0), 0, 48'd0,
                           gma_pkg::ST_OK});
    table_rows.push_back('{mk(gma_pkg::CMD_EDGE, 1023, 1023, 255, -32768, 0), 0, 48'd0,
                           gma_pkg::ST_OK});
    table_rows.push_back('{mk(gma_pkg::CMD_EDGE, 1, 0, 0, 256, 0), 0, 48'd0,
                           gma_pkg::ST_OK});
    table_rows.push_back('{mk(gma_pkg::CMD_EDGE, 0, 1, 0, 32767, 0), 0, 48'd0,
                           gma_pkg::ST_OK});
    table_rows.push_back('{mk(gma_pkg::CMD_EDGE, 1, 1, 0, -32768, 0), 0, 48'd0,
                           gma_pkg::ST_OK});
    table_rows.push_back('{mk(gma_pkg::CMD_EDGE, 0, 1023, 0, 0, 0), 0, 48'd0,
                           gma_pkg::ST_OK});
    table_rows.push_back('{mk(gma_pkg::CMD_EDGE, 1, 1, 0, -1, 1), 0, 48'd0,
                           gma_pkg::ST_OK});
    table_rows.push_back('{mk(gma_pkg::CMD_LABEL, 5, 0, 3, 0, 1), 1, 48'd0,
                           gma_pkg::ST_EMPTY});
    table_rows.push_back('{mk(gma_pkg::CMD_EDGE, 5, 5, 0, 1, 0), 0, 48'd0,
                           gma_pkg::ST_OK});
    table_rows.push_back('{mk(gma_pkg::CMD_LABEL, 6, 0, 3, 0, 1), 0, 48'd0,
                           gma_pkg::ST_OK});
    table_rows.push_back('{mk(gma_pkg::CMD_EDGE, 1023, 5, 0, 32767, 0), 0, 48'd0,
                           gma_pkg::ST_OK});
    table_rows.push_back('{mk(gma_pkg::CMD_EDGE, 6, 5, 0, -32768, 1), 0, 48'd0,
                           gma_pkg::ST_OK});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (table_rows[i])
      send_item(table_rows[i].item, table_rows[i].typed, table_rows[i].score,
                table_rows[i].status);

    // Random graphs, each under its own cluster count.
    phase = 0;
    while (items_sent < 1300) begin
      drain();
      case (phase)
        0: cc = 0;
        1: cc = 511;
        2: cc = 256;
        3: cc = 1;
        default: cc = ($urandom_range(0, 19) == 0) ? 256 : $urandom_range(1, 8);
      endcase
      write_clusters(cc);
      quiet_send = (phase % 5 == 2);
      quiet_recv = (phase % 7 == 3);
      pool = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(3, 24);

      nlabels = $urandom_range(2, 12);
      for (int i = 0; i < nlabels; i++) begin
        it = mk(gma_pkg::CMD_LABEL, $urandom_range(0, pool), $urandom, 0, $urandom, 0);
        it.label = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                : 8'($urandom_range(0, (cc > 9) ? 9 : cc));
        send_item(it, 0, '0, gma_pkg::ST_OK);
      end

      nedges = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 30);
      for (int i = 0; i < nedges; i++) begin
        it = mk(gma_pkg::CMD_EDGE, $urandom_range(0, pool), $urandom_range(0, pool),
                $urandom, $urandom, 0);
        // Occasional noise: full-range nodes and a stray label load.
        if ($urandom_range(0, 15) == 0) begin
          it.row = 10'($urandom);
          it.col = 10'($urandom);
        end
        if ($urandom_range(0, 24) == 0) it.cmd = gma_pkg::CMD_LABEL;
        it.last = (i == nedges - 1);
        send_item(it, 0, '0, gma_pkg::ST_OK);
      end
      // An empty graph or a stray label ends on a label load.
      if (nedges == 0 || $urandom_range(0, 15) == 0) begin
        it = mk(gma_pkg::CMD_LABEL, $urandom_range(0, pool), $urandom,
                $urandom_range(0, 3), $urandom, 1);
        if (nedges != 0) begin
          it.last = 1;
        end
        send_item(it, 0, '0, gma_pkg::ST_OK);
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (score_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d items over %0d graphs and checked %0d results,", items_sent,
             phase, results_seen);
    $display("with cluster counts from zero to the maximum and random stalls on both sides.");
    if (errors == 0) begin
      $display("graph_modularity_accumulator: match");
    end else begin
      $display("graph_modularity_accumulator: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/gma_pkg.sv
rtl/gma_label_store.sv
rtl/gma_cluster_acc.sv
rtl/gma_divider.sv
rtl/graph_modularity_accumulator.sv
rtl/gma_checker.sv
tb/sv/graph_modularity_accumulator_tb.sv
